// ===== sv/pesr_pkg.sv =====
// Package: shared types and constants for the equal-step polyline resampler.
`timescale 1ns / 1ps
`default_nettype none
package pesr_pkg;
  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS = 8;
  localparam int STEP_BITS = 24;
  localparam int ROOT_BITS = COORD_BITS + 1 + FRAC_BITS;
  localparam int SQ_BITS = 2 * COORD_BITS + 1;
  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int QUO_BITS = COORD_BITS;
  localparam int NUM_BITS = COORD_BITS + STEP_BITS;
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(256);

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic is_first;
    logic is_final;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic end_of_run;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic root_start;
    logic root_step;
    logic div_start;
    logic div_step;
    logic keep_input;
    logic keep_interp;
    logic keep_first;
    logic keep_final;
    logic emit_input;
    logic emit_end;
    logic emit_interp;
  } cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_final;
    logic short_hop;
    logic zero_root;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/pesr_datapath.sv =====
// Datapath: distance root, interpolation dividers, kept point and budget.
`timescale 1ns / 1ps
`default_nettype none
module pesr_datapath (
  input  wire logic clk,
  input  wire pesr_pkg::in_item_t in_item,
  input  wire logic [pesr_pkg::STEP_BITS-1:0] step_length,
  input  wire logic rst,
  input  wire pesr_pkg::cmd_t cmd,
  output pesr_pkg::stat_t stat,
  output pesr_pkg::out_item_t result
);
  import pesr_pkg::*;

  logic [COORD_BITS-1:0] px, py, kept_x, kept_y, dx, dy, qx, qy;
  logic sx, sy, fst, fin;
  logic [STEP_BITS-1:0] remaining;
  logic [SQ_BITS-1:0] sq;
  logic [RAD_BITS-1:0] rad;
  logic [ROOT_BITS+1:0] rrem, rtrial, rrem_sh;
  logic [ROOT_BITS-1:0] root;
  logic [NUM_BITS-1:0] nx, ny;
  logic [ROOT_BITS:0] remx, remy, remx_sh, remy_sh;
  logic [COORD_BITS-1:0] ix, iy;

  always_comb begin
    rrem_sh = {rrem[ROOT_BITS-1:0], rad[RAD_BITS-1 -: 2]};
    rtrial = {root, 2'b01};
    remx_sh = {remx[ROOT_BITS-1:0], nx[NUM_BITS-1]};
    remy_sh = {remy[ROOT_BITS-1:0], ny[NUM_BITS-1]};
    ix = sx ? kept_x + qx : kept_x - qx;
    iy = sy ? kept_y + qy : kept_y - qy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_x <= '0;
      kept_y <= '0;
      remaining <= '0;
    end else begin
      if (cmd.keep_input) begin
        kept_x <= px;
        kept_y <= py;
        remaining <= remaining - STEP_BITS'(root);
      end
      if (cmd.keep_interp) begin
        kept_x <= ix;
        kept_y <= iy;
        remaining <= step_length;
      end
      if (cmd.keep_first) begin
        kept_x <= px;
        kept_y <= py;
        remaining <= step_length;
      end
      if (cmd.keep_final) begin
        kept_x <= px;
        kept_y <= py;
        remaining <= '0;
      end
    end
    if (cmd.load) begin
      px <= in_item.point_x;
      py <= in_item.point_y;
      fst <= in_item.is_first;
      fin <= in_item.is_final;
    end
    if (cmd.sq_start) begin
      sx <= px >= kept_x;
      sy <= py >= kept_y;
      dx <= (px >= kept_x) ? px - kept_x : kept_x - px;
      dy <= (py >= kept_y) ? py - kept_y : kept_y - py;
    end
    if (cmd.root_start) begin
      sq <= SQ_BITS'(dx * dx) + SQ_BITS'(dy * dy);
      rrem <= '0;
      root <= '0;
    end
    if (cmd.div_start) begin
      rad <= {1'b0, sq, (2 * FRAC_BITS)'(0)};
    end
    if (cmd.root_step) begin
      rad <= {rad[RAD_BITS-3:0], 2'b00};
      if (rrem_sh >= rtrial) begin
        rrem <= rrem_sh - rtrial;
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rrem <= rrem_sh;
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.emit_input || cmd.emit_end) begin
      result <= '{out_x: px, out_y: py, end_of_run: cmd.emit_end};
    end
    if (cmd.emit_interp) begin
      result <= '{out_x: ix, out_y: iy, end_of_run: 1'b0};
    end
  end

  // restoring dividers for |delta| * remaining / root
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      nx <= NUM_BITS'(dx) * NUM_BITS'(remaining);
      ny <= NUM_BITS'(dy) * NUM_BITS'(remaining);
      remx <= '0;
      remy <= '0;
      qx <= '0;
      qy <= '0;
    end else if (cmd.div_step) begin
      nx <= {nx[NUM_BITS-2:0], 1'b0};
      ny <= {ny[NUM_BITS-2:0], 1'b0};
      if (remx_sh >= {1'b0, root}) begin
        remx <= remx_sh - {1'b0, root};
        qx <= {qx[COORD_BITS-2:0], 1'b1};
      end else begin
        remx <= remx_sh;
        qx <= {qx[COORD_BITS-2:0], 1'b0};
      end
      if (remy_sh >= {1'b0, root}) begin
        remy <= remy_sh - {1'b0, root};
        qy <= {qy[COORD_BITS-2:0], 1'b1};
      end else begin
        remy <= remy_sh;
        qy <= {qy[COORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat = '{is_first: fst, is_final: fin,
                  short_hop: remaining < STEP_BITS'(root), zero_root: root == '0};
endmodule
`default_nettype wire

// ===== sv/pesr_ctrl.sv =====
// Controller: sequences root and divide steps and the output handshake.
`timescale 1ns / 1ps
`default_nettype none
module pesr_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire pesr_pkg::stat_t stat,
  output pesr_pkg::cmd_t cmd
);
  import pesr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DECODE = 4'd1, S_SQ = 4'd2, S_RAD = 4'd3,
    S_ROOT = 4'd4, S_CHECK = 4'd5, S_DIV0 = 4'd6, S_DIV = 4'd7, S_UPD = 4'd8,
    S_OUT = 4'd9, S_OUT2 = 4'd10, S_ROOTI = 4'd11;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [3:0] state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic out_valid_next, two, two_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    out_valid_next = out_valid && out_stall;
    two_next = two;
    cmd = '0;
    in_stall = state != S_IDLE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.is_final) begin
          if (!out_valid) begin
            cmd.emit_input = 1'b1;
            cmd.keep_final = 1'b1;
            out_valid_next = 1'b1;
            two_next = 1'b1;
            state_next = S_OUT2;
          end
        end else if (stat.is_first) begin
          if (!out_valid) begin
            cmd.emit_input = 1'b1;
            cmd.keep_first = 1'b1;
            out_valid_next = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.sq_start = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.root_start = 1'b1;
        state_next = S_RAD;
      end
      S_RAD: begin
        cmd.div_start = 1'b1;
        state_next = S_ROOTI;
      end
      S_ROOTI: begin
        cnt_next = CNT_BITS'(ROOT_BITS);
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.short_hop && !stat.zero_root) state_next = S_DIV0;
        else begin
          cmd.keep_input = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        cnt_next = CNT_BITS'(NUM_BITS);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) state_next = S_UPD;
      end
      S_UPD: if (!out_valid) begin
        cmd.emit_interp = 1'b1;
        cmd.keep_interp = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_OUT2: if (!out_valid || !out_stall) begin
        cmd.emit_end = 1'b1;
        out_valid_next = 1'b1;
        two_next = 1'b0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      two <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
      two <= two_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_two: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT2 |-> two) else $error("second copy lost");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT |-> in_stall) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

// ===== sv/polyline_equal_step_resampler.sv =====
// Top level: equal-step polyline resampler.
// Input channel in_item/in_valid/in_stall takes one contour point per item.
// Output channel result/out_valid/out_stall carries emitted sample points.
// Config channel cfg_valid/cfg_ready/cfg_data writes step_length (Q16.8).
// A first point emits one item; a final point emits two items, the second
// with end_of_run set. Other points go through the bit-serial square root
// and, when a sample falls between points, the bit-serial divider.
// One item is processed at a time; the result register lets the next
// point be accepted while a result waits. A stalled receiver holds result
// and blocks the block only when a new result is ready.
// Reset clears kept point and budget to zero and step_length to 256.
`timescale 1ns / 1ps
`default_nettype none
module polyline_equal_step_resampler (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pesr_pkg::in_item_t in_item,
  input  wire logic in_valid,
  output logic in_stall,
  output pesr_pkg::out_item_t result,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [pesr_pkg::STEP_BITS-1:0] cfg_data
);
  import pesr_pkg::*;

  logic [STEP_BITS-1:0] step_length;
  cmd_t cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) step_length <= STEP_RESET;
    else if (cfg_valid) step_length <= cfg_data;
  end

  pesr_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd);
  pesr_datapath u_dp (.clk, .rst, .in_item, .step_length, .cmd, .stat, .result);
endmodule
`default_nettype wire
